FILE: hdl/gfau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types and constants of the GF(2^m) arithmetic unit: operation codes,
// sequencer states, run phases and the control and status bundles.
// ----------------------------------------------------------------------------
package gfau_pkg;

	localparam int FIELD_BITS_DEF = 16;
	localparam int OPERAND_BITS   = 16;
	localparam int POLY_BITS      = 17;
	localparam int PADDR_BITS     = 3;
	localparam int PDATA_BITS     = 32;
	localparam logic [POLY_BITS-1:0] POLY_RESET = 17'd283;

	typedef enum logic [1:0] {
		CMD_MUL = 2'd0,
		CMD_INV = 2'd1,
		CMD_POW = 2'd2,
		CMD_RED = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_NEXT,
		ST_EUC,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		PH_RED_B,
		PH_RED_A,
		PH_MUL,
		PH_RED_OUT,
		PH_RED_INV,
		PH_POW_BASE,
		PH_SQR,
		PH_MULB
	} phase_t;

	typedef enum logic [1:0] {
		XS_ONE,
		XS_Z,
		XS_AUX
	} xsel_t;

	typedef enum logic [2:0] {
		YS_A,
		YS_B,
		YS_Z,
		YS_ONE,
		YS_AUX
	} ysel_t;

	typedef enum logic [1:0] {
		RS_ZERO,
		RS_Z,
		RS_T
	} rsel_t;

	typedef struct packed {
		logic  start;
		logic  run_load;
		xsel_t x_sel;
		ysel_t y_sel;
		logic  run_step;
		logic  aux_load;
		logic  euc_init;
		logic  euc_step;
		logic  res_load;
		rsel_t res_sel;
	} ctrl_t;

	typedef struct packed {
		logic degen;
		logic r0_zero;
	} status_t;

endpackage

FILE: hdl/gfau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_datapath
// Operand registers, the shared shift/reduce/accumulate step used for both
// reduction and multiplication, the Euclid registers and the result register.
// ----------------------------------------------------------------------------
module gfau_datapath #(
	parameter int FIELD_BITS = gfau_pkg::FIELD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gfau_pkg::ctrl_t                   ctrl,
	output gfau_pkg::status_t                 status,
	input  logic [FIELD_BITS:0]               p_in,
	input  logic [gfau_pkg::OPERAND_BITS-1:0] operand_a,
	input  logic [gfau_pkg::OPERAND_BITS-1:0] operand_b,
	output logic [gfau_pkg::OPERAND_BITS-1:0] result
);

	localparam int W  = FIELD_BITS;
	localparam int PW = FIELD_BITS + 1;
	localparam int DW = $clog2(PW);
	localparam int OB = gfau_pkg::OPERAND_BITS;

	logic [PW-1:0] p_q;
	logic [DW-1:0] m_q;
	logic          degen_q;
	logic [OB-1:0] a_q, b_q;
	logic [W-1:0]  x_q, z_q, aux_q;
	logic [OB-1:0] y_q;
	logic [PW-1:0] r0_q, r1_q, t0_q, t1_q;
	logic [DW-1:0] dr1_q;
	logic [OB-1:0] res_q;

	logic [PW-1:0] enc_in;
	logic [DW-1:0] enc_deg;
	logic          enc_nz;

	logic [PW-1:0] z_shl, z_red;
	logic [W-1:0]  z_nxt;
	logic          r0_ge;
	logic [DW-1:0] shamt;
	logic [PW-1:0] t_fin;

	// one leading-bit scan, used on the polynomial at accept and on r0 after
	assign enc_in = ctrl.start ? p_in : r0_q;

	always_comb begin
		enc_deg = '0;
		enc_nz  = 1'b0;
		for (int i = 0; i < PW; i++) begin
			if (enc_in[i]) begin
				enc_deg = DW'(i);
				enc_nz  = 1'b1;
			end
		end
	end

	// z <- (2z mod p) xor (top multiplier bit ? x : 0)
	assign z_shl = {z_q, 1'b0};
	assign z_red = z_shl ^ (z_shl[m_q] ? p_q : '0);
	assign z_nxt = z_red[W-1:0] ^ (y_q[OB-1] ? x_q : '0);

	assign r0_ge = enc_deg >= dr1_q;
	assign shamt = enc_deg - dr1_q;
	// bezout coefficient has degree at most m, one conditional xor reduces it
	assign t_fin = t1_q ^ (t1_q[m_q] ? p_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= '0;
			m_q     <= '0;
			degen_q <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			x_q     <= '0;
			z_q     <= '0;
			aux_q   <= '0;
			y_q     <= '0;
			r0_q    <= '0;
			r1_q    <= '0;
			t0_q    <= '0;
			t1_q    <= '0;
			dr1_q   <= '0;
			res_q   <= '0;
		end else begin
			if (ctrl.start) begin
				p_q     <= p_in;
				m_q     <= enc_deg;
				degen_q <= !enc_nz || (enc_deg == '0);
				a_q     <= operand_a;
				b_q     <= operand_b;
			end

			if (ctrl.run_load) begin
				z_q <= '0;
				case (ctrl.x_sel)
					gfau_pkg::XS_Z:   x_q <= z_q;
					gfau_pkg::XS_AUX: x_q <= aux_q;
					default:          x_q <= W'(1);
				endcase
				case (ctrl.y_sel)
					gfau_pkg::YS_A:   y_q <= a_q;
					gfau_pkg::YS_B:   y_q <= b_q;
					gfau_pkg::YS_Z:   y_q <= OB'(z_q);
					gfau_pkg::YS_AUX: y_q <= OB'(aux_q);
					default:          y_q <= OB'(1);
				endcase
			end else if (ctrl.run_step) begin
				z_q <= z_nxt;
				y_q <= {y_q[OB-2:0], 1'b0};
			end

			if (ctrl.aux_load) begin
				aux_q <= z_q;
			end

			if (ctrl.euc_init) begin
				r0_q  <= PW'(z_q);
				r1_q  <= p_q;
				t0_q  <= PW'(1);
				t1_q  <= '0;
				dr1_q <= m_q;
			end else if (ctrl.euc_step) begin
				if (r0_ge) begin
					r0_q <= r0_q ^ (r1_q << shamt);
					t0_q <= t0_q ^ (t1_q << shamt);
				end else begin
					r0_q  <= r1_q;
					r1_q  <= r0_q;
					t0_q  <= t1_q;
					t1_q  <= t0_q;
					dr1_q <= enc_deg;
				end
			end

			if (ctrl.res_load) begin
				case (ctrl.res_sel)
					gfau_pkg::RS_Z: res_q <= OB'(z_q);
					gfau_pkg::RS_T: res_q <= OB'(t_fin[W-1:0]);
					default:        res_q <= '0;
				endcase
			end
		end
	end

	assign status.degen   = degen_q;
	assign status.r0_zero = !enc_nz;
	assign result         = res_q;

endmodule

FILE: hdl/gfau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_ctrl
// Sequencer: walks each operation through its reduce, multiply and Euclid
// runs on the shared datapath and owns both channel handshakes.
// ----------------------------------------------------------------------------
module gfau_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        cmd,
	input  logic [gfau_pkg::OPERAND_BITS-1:0] exponent,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	input  gfau_pkg::status_t                 status,
	output gfau_pkg::ctrl_t                   ctrl
);

	localparam int OB = gfau_pkg::OPERAND_BITS;
	localparam int CW = $clog2(OB);
	localparam logic [CW-1:0] LAST = CW'(OB - 1);

	gfau_pkg::state_t state_q, state_d;
	gfau_pkg::phase_t phase_q, phase_nxt;
	gfau_pkg::cmd_t   cmd_q;
	logic [CW-1:0]    cnt_q, bit_cnt_q;
	logic [OB-1:0]    e_q;
	logic             rsp_valid_q;
	logic             phase_we, bit_init, pow_adv;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gfau_pkg::ST_IDLE: begin
				if (req_valid) state_d = gfau_pkg::ST_CHECK;
			end
			gfau_pkg::ST_CHECK: begin
				state_d = status.degen ? gfau_pkg::ST_FIN : gfau_pkg::ST_RUN;
			end
			gfau_pkg::ST_RUN: begin
				if (cnt_q == LAST) state_d = gfau_pkg::ST_NEXT;
			end
			gfau_pkg::ST_NEXT: begin
				case (phase_q)
					gfau_pkg::PH_MUL, gfau_pkg::PH_RED_OUT: state_d = gfau_pkg::ST_FIN;
					gfau_pkg::PH_RED_INV: state_d = gfau_pkg::ST_EUC;
					gfau_pkg::PH_SQR: begin
						if (!e_q[OB-1] && bit_cnt_q == '0) state_d = gfau_pkg::ST_FIN;
						else state_d = gfau_pkg::ST_RUN;
					end
					gfau_pkg::PH_MULB: begin
						state_d = (bit_cnt_q == '0) ? gfau_pkg::ST_FIN : gfau_pkg::ST_RUN;
					end
					default: state_d = gfau_pkg::ST_RUN;
				endcase
			end
			gfau_pkg::ST_EUC: begin
				if (status.r0_zero) state_d = gfau_pkg::ST_FIN;
			end
			gfau_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) state_d = gfau_pkg::ST_IDLE;
			end
			default: state_d = gfau_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl      = '0;
		phase_nxt = phase_q;
		phase_we  = 1'b0;
		bit_init  = 1'b0;
		pow_adv   = 1'b0;
		case (state_q)
			gfau_pkg::ST_IDLE: begin
				ctrl.start = req_valid;
			end
			gfau_pkg::ST_CHECK: begin
				if (!status.degen) begin
					ctrl.run_load = 1'b1;
					ctrl.x_sel    = gfau_pkg::XS_ONE;
					ctrl.y_sel    = gfau_pkg::YS_A;
					phase_we      = 1'b1;
					case (cmd_q)
						gfau_pkg::CMD_MUL: begin
							ctrl.y_sel = gfau_pkg::YS_B;
							phase_nxt  = gfau_pkg::PH_RED_B;
						end
						gfau_pkg::CMD_INV: phase_nxt = gfau_pkg::PH_RED_INV;
						gfau_pkg::CMD_POW: phase_nxt = gfau_pkg::PH_POW_BASE;
						default:           phase_nxt = gfau_pkg::PH_RED_OUT;
					endcase
				end
			end
			gfau_pkg::ST_RUN: begin
				ctrl.run_step = 1'b1;
			end
			gfau_pkg::ST_NEXT: begin
				case (phase_q)
					gfau_pkg::PH_RED_B: begin
						ctrl.aux_load = 1'b1;
						ctrl.run_load = 1'b1;
						ctrl.x_sel    = gfau_pkg::XS_ONE;
						ctrl.y_sel    = gfau_pkg::YS_A;
						phase_we      = 1'b1;
						phase_nxt     = gfau_pkg::PH_RED_A;
					end
					gfau_pkg::PH_RED_A: begin
						ctrl.run_load = 1'b1;
						ctrl.x_sel    = gfau_pkg::XS_Z;
						ctrl.y_sel    = gfau_pkg::YS_AUX;
						phase_we      = 1'b1;
						phase_nxt     = gfau_pkg::PH_MUL;
					end
					gfau_pkg::PH_RED_INV: begin
						ctrl.euc_init = 1'b1;
					end
					gfau_pkg::PH_POW_BASE: begin
						// base kept aside, accumulator starts at one
						ctrl.aux_load = 1'b1;
						ctrl.run_load = 1'b1;
						ctrl.x_sel    = gfau_pkg::XS_ONE;
						ctrl.y_sel    = gfau_pkg::YS_ONE;
						phase_we      = 1'b1;
						phase_nxt     = gfau_pkg::PH_SQR;
						bit_init      = 1'b1;
					end
					gfau_pkg::PH_SQR: begin
						if (e_q[OB-1]) begin
							ctrl.run_load = 1'b1;
							ctrl.x_sel    = gfau_pkg::XS_AUX;
							ctrl.y_sel    = gfau_pkg::YS_Z;
							phase_we      = 1'b1;
							phase_nxt     = gfau_pkg::PH_MULB;
						end else if (bit_cnt_q != '0) begin
							pow_adv       = 1'b1;
							ctrl.run_load = 1'b1;
							ctrl.x_sel    = gfau_pkg::XS_Z;
							ctrl.y_sel    = gfau_pkg::YS_Z;
						end
					end
					gfau_pkg::PH_MULB: begin
						if (bit_cnt_q != '0) begin
							pow_adv       = 1'b1;
							ctrl.run_load = 1'b1;
							ctrl.x_sel    = gfau_pkg::XS_Z;
							ctrl.y_sel    = gfau_pkg::YS_Z;
							phase_we      = 1'b1;
							phase_nxt     = gfau_pkg::PH_SQR;
						end
					end
					default: ;
				endcase
			end
			gfau_pkg::ST_EUC: begin
				ctrl.euc_step = !status.r0_zero;
			end
			gfau_pkg::ST_FIN: begin
				ctrl.res_load = !rsp_valid_q || rsp_ready;
				if (status.degen)                  ctrl.res_sel = gfau_pkg::RS_ZERO;
				else if (cmd_q == gfau_pkg::CMD_INV) ctrl.res_sel = gfau_pkg::RS_T;
				else                               ctrl.res_sel = gfau_pkg::RS_Z;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfau_pkg::ST_IDLE;
			phase_q     <= gfau_pkg::PH_RED_OUT;
			cmd_q       <= gfau_pkg::CMD_MUL;
			cnt_q       <= '0;
			bit_cnt_q   <= '0;
			e_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (phase_we) phase_q <= phase_nxt;
			if (ctrl.start) begin
				cmd_q <= gfau_pkg::cmd_t'(cmd);
				e_q   <= exponent;
			end else if (pow_adv) begin
				e_q <= {e_q[OB-2:0], 1'b0};
			end
			if (ctrl.run_load)      cnt_q <= '0;
			else if (ctrl.run_step) cnt_q <= cnt_q + 1'b1;
			if (bit_init)     bit_cnt_q <= LAST;
			else if (pow_adv) bit_cnt_q <= bit_cnt_q - 1'b1;
			if (ctrl.res_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == gfau_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: hdl/gf2m_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit
// GF(2^m) polynomial-basis arithmetic: multiply, inverse, power and reduce,
// with the field polynomial held in a register on the APB-style port.
// ----------------------------------------------------------------------------
// Usage:
//   request beat: cmd, operand_a, operand_b, exponent on req_valid/req_ready.
//   response beat: result on rsp_valid/rsp_ready, one per request.
//   field_poly sits at byte address 0; write it only while the unit is idle.
//   One item at a time. Every pass of the shared step unit walks a 16-bit
//   multiplier, and a further state sets up the next pass. From accept to
//   rsp_valid an item runs:
//     reduce   one reducing pass
//     multiply reduce b, reduce a, multiply
//     inverse  a reducing pass of the operand, then one Euclid shift-xor or
//              swap per cycle until r0 is zero
//     power    reduce the base, then square and multiply from the top exponent bit down
//   A polynomial of degree below one answers 0.
//   req_ready is high only when idle. The result register holds a finished
//   beat while rsp_ready is low; the next item may be accepted meanwhile and
//   waits at its end until the earlier beat is taken.
//   Reset clears rsp_valid, returns the unit to idle and sets field_poly to 0x11B.
// ----------------------------------------------------------------------------
module gf2m_arithmetic_unit #(
	parameter int FIELD_BITS = gfau_pkg::FIELD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        cmd,
	input  logic [gfau_pkg::OPERAND_BITS-1:0] operand_a,
	input  logic [gfau_pkg::OPERAND_BITS-1:0] operand_b,
	input  logic [gfau_pkg::OPERAND_BITS-1:0] exponent,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [gfau_pkg::OPERAND_BITS-1:0] result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gfau_pkg::PADDR_BITS-1:0]   paddr,
	input  logic [gfau_pkg::PDATA_BITS-1:0]   pwdata,
	output logic [gfau_pkg::PDATA_BITS-1:0]   prdata,
	output logic                              pready
);

	localparam int PB = gfau_pkg::POLY_BITS;
	localparam int DB = gfau_pkg::PDATA_BITS;

	logic [PB-1:0]     field_poly_q;
	gfau_pkg::ctrl_t   ctrl;
	gfau_pkg::status_t status;

	// register index is the word address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_poly_q <= gfau_pkg::POLY_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			field_poly_q <= pwdata[PB-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : DB'(field_poly_q);

	gfau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.exponent  (exponent),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	gfau_datapath #(
		.FIELD_BITS (FIELD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.p_in      (field_poly_q[FIELD_BITS:0]),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.result    (result)
	);

endmodule

FILE: hdl/gfau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_checker
// Port-level checks of the GF(2^m) arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module gfau_checker #(
	parameter int FIELD_BITS = gfau_pkg::FIELD_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [gfau_pkg::OPERAND_BITS-1:0] result
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result))
		else $error("response beat changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// a response is only produced at the end of an item, never from idle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without an item in flight");

	// results never have bits set at or above FIELD_BITS
	a_result_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((result >> FIELD_BITS) == '0))
		else $error("result wider than the field");

endmodule

bind gf2m_arithmetic_unit gfau_checker #(
	.FIELD_BITS (FIELD_BITS)
) u_gfau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.result    (result)
);
